// File: rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, switched off while rst_ni is low.
`define SCS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Implication form of the above.
`define SCS_ASSERT_IMPL(label, pre, post) \
  `SCS_ASSERT(label, (pre) |-> (post))

`endif

// File: rtl/scs_pkg.sv
// Types, constants and lookup functions of the sine commutation sequencer.
`default_nettype none

package scs_pkg;

  localparam int unsigned StepsPerSector = 20;
  localparam int unsigned SineLen        = 40;

  localparam int unsigned PeriodW  = 16;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned AmpW     = 7;
  localparam int unsigned SineW    = 17;
  localparam int unsigned SectorW  = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned Phases   = 3;

  localparam int unsigned SubW     = $clog2(StepsPerSector + 1);
  localparam int unsigned IdxW     = $clog2(SineLen);
  localparam int unsigned IdxCalcW = ($clog2(2 * StepsPerSector) > IdxW) ?
                                     $clog2(2 * StepsPerSector) : IdxW;

  localparam logic [SectorW-1:0] SectorFirst = 3'd0;
  localparam logic [SectorW-1:0] SectorReset = 3'd2;
  localparam logic [SectorW-1:0] SectorLast  = 3'd5;

  // Period thresholds for the amplitude steps.
  localparam logic [PeriodW-1:0] Thr10 = 16'd1300;
  localparam logic [PeriodW-1:0] Thr20 = 16'd570;
  localparam logic [PeriodW-1:0] Thr30 = 16'd350;
  localparam logic [PeriodW-1:0] Thr40 = 16'd270;
  localparam logic [PeriodW-1:0] Thr50 = 16'd180;
  localparam logic [PeriodW-1:0] Thr60 = 16'd160;

  typedef enum logic [2:0] {
    SEL_RISE,
    SEL_FALL,
    SEL_RISE2,
    SEL_FALL2,
    SEL_FLOOR
  } sel_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FORWARD    = 1'b0,
    CFG_FLOOR_DUTY = 1'b1
  } cfg_idx_e;

  // Element 0 is phase 1.
  typedef sel_e [Phases-1:0] pattern_t;

  typedef struct packed {
    logic [PeriodW-1:0]           period;
    logic [AmpW-1:0]              amp;
    logic [Phases-1:0][IdxW-1:0]  idx;
    logic [Phases-1:0]            use_floor;
    logic                         enable;
  } stage_t;

  function automatic logic [AmpW-1:0] amplitude(input logic [PeriodW-1:0] period);
    logic [AmpW-1:0] amp;
    if (period > Thr10)      amp = 7'd10;
    else if (period > Thr20) amp = 7'd20;
    else if (period > Thr30) amp = 7'd30;
    else if (period > Thr40) amp = 7'd40;
    else if (period > Thr50) amp = 7'd50;
    else if (period > Thr60) amp = 7'd60;
    else                     amp = 7'd70;
    return amp;
  endfunction

  // Sine samples in Q1.16, rising to 1.0 at index 32 and falling after it.
  function automatic logic [SineW-1:0] sine_q16(input logic [IdxW-1:0] idx);
    logic [SineW-1:0] s;
    case (idx)
      6'd0:  s = 17'd3118;
      6'd1:  s = 17'd6230;
      6'd2:  s = 17'd9327;
      6'd3:  s = 17'd12403;
      6'd4:  s = 17'd15451;
      6'd5:  s = 17'd18464;
      6'd6:  s = 17'd21435;
      6'd7:  s = 17'd24357;
      6'd8:  s = 17'd27225;
      6'd9:  s = 17'd30030;
      6'd10: s = 17'd32768;
      6'd11: s = 17'd35431;
      6'd12: s = 17'd38015;
      6'd13: s = 17'd40512;
      6'd14: s = 17'd42917;
      6'd15: s = 17'd45225;
      6'd16: s = 17'd47431;
      6'd17: s = 17'd49529;
      6'd18: s = 17'd51515;
      6'd19: s = 17'd53384;
      6'd20: s = 17'd55132;
      6'd21: s = 17'd56756;
      6'd22: s = 17'd58251;
      6'd23: s = 17'd59614;
      6'd24: s = 17'd60842;
      6'd25: s = 17'd61932;
      6'd26: s = 17'd62881;
      6'd27: s = 17'd63689;
      6'd28: s = 17'd64352;
      6'd29: s = 17'd64869;
      6'd30: s = 17'd65239;
      6'd31: s = 17'd65462;
      6'd32: s = 17'd65536;
      6'd33: s = 17'd65462;
      6'd34: s = 17'd65239;
      6'd35: s = 17'd64869;
      6'd36: s = 17'd64352;
      6'd37: s = 17'd63689;
      6'd38: s = 17'd62881;
      6'd39: s = 17'd61932;
      default: s = '0;
    endcase
    return s;
  endfunction

  // Table segment used by each phase, per direction and sector.
  function automatic pattern_t pattern(input logic forward,
                                       input logic [SectorW-1:0] sector);
    pattern_t p;
    case ({forward, sector})
      4'b0_000: p = {SEL_FALL,  SEL_FALL2, SEL_FLOOR};
      4'b0_001: p = {SEL_RISE2, SEL_RISE,  SEL_FLOOR};
      4'b0_010: p = {SEL_FALL2, SEL_FLOOR, SEL_FALL};
      4'b0_011: p = {SEL_RISE,  SEL_FLOOR, SEL_RISE2};
      4'b0_100: p = {SEL_FLOOR, SEL_FALL,  SEL_FALL2};
      4'b0_101: p = {SEL_FLOOR, SEL_RISE2, SEL_RISE};
      4'b1_000: p = {SEL_RISE,  SEL_FALL2, SEL_FLOOR};
      4'b1_001: p = {SEL_RISE2, SEL_FALL,  SEL_FLOOR};
      4'b1_010: p = {SEL_FALL2, SEL_FLOOR, SEL_RISE};
      4'b1_011: p = {SEL_FALL,  SEL_FLOOR, SEL_RISE2};
      4'b1_100: p = {SEL_FLOOR, SEL_RISE,  SEL_FALL2};
      4'b1_101: p = {SEL_FLOOR, SEL_RISE2, SEL_FALL};
      default:  p = {SEL_FLOOR, SEL_FLOOR, SEL_FLOOR};
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// File: rtl/scs_front.sv
// Input stage: sub-step and sector sequencing, amplitude and table index selection.
`default_nettype none

module scs_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [scs_pkg::PeriodW-1:0]  reload_period_i,
  input  wire logic                         forward_i,
  input  wire logic                         down_ready_i,
  output logic                              stage_valid_o,
  output scs_pkg::stage_t                   stage_o
);

  logic                             valid_q;
  scs_pkg::stage_t                  stage_q, stage_d;
  logic [scs_pkg::SubW-1:0]         sub_step_q, sub_step_d;
  logic [scs_pkg::SectorW-1:0]      sector_q, sector_d;
  logic                             wrap;
  logic [scs_pkg::SubW-1:0]         step;
  scs_pkg::pattern_t                pat;
  logic [scs_pkg::IdxCalcW-1:0]     raw;
  logic                             accept;

  assign in_ready_o    = !valid_q || down_ready_i;
  assign accept        = in_valid_i && in_ready_o;
  assign stage_valid_o = valid_q;
  assign stage_o       = stage_q;

  always_comb begin
    wrap = sub_step_q >= scs_pkg::SubW'(scs_pkg::StepsPerSector);
    step = wrap ? '0 : sub_step_q;
    sector_d = sector_q;
    if (wrap) begin
      if (forward_i) begin
        sector_d = (sector_q >= scs_pkg::SectorLast) ? scs_pkg::SectorFirst
                                                     : sector_q + 1'b1;
      end else begin
        sector_d = (sector_q == scs_pkg::SectorFirst) ? scs_pkg::SectorLast
                                                      : sector_q - 1'b1;
      end
    end
    sub_step_d = step + 1'b1;
    pat = scs_pkg::pattern(forward_i, sector_d);

    stage_d.period = reload_period_i;
    stage_d.amp    = scs_pkg::amplitude(reload_period_i);
    stage_d.enable = (step == '0);
    for (int p = 0; p < scs_pkg::Phases; p++) begin
      stage_d.use_floor[p] = 1'b0;
      case (pat[p])
        scs_pkg::SEL_RISE:  raw = scs_pkg::IdxCalcW'(step);
        scs_pkg::SEL_FALL:  raw = scs_pkg::IdxCalcW'(scs_pkg::StepsPerSector - 1)
                                  - scs_pkg::IdxCalcW'(step);
        scs_pkg::SEL_RISE2: raw = scs_pkg::IdxCalcW'(step)
                                  + scs_pkg::IdxCalcW'(scs_pkg::StepsPerSector);
        scs_pkg::SEL_FALL2: raw = scs_pkg::IdxCalcW'(2 * scs_pkg::StepsPerSector - 1)
                                  - scs_pkg::IdxCalcW'(step);
        default: begin
          raw = '0;
          stage_d.use_floor[p] = 1'b1;
        end
      endcase
      // Longer sectors would run past the table; hold at its last entry.
      if (raw > scs_pkg::IdxCalcW'(scs_pkg::SineLen - 1)) begin
        stage_d.idx[p] = scs_pkg::IdxW'(scs_pkg::SineLen - 1);
      end else begin
        stage_d.idx[p] = raw[scs_pkg::IdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      sub_step_q <= '0;
      sector_q   <= scs_pkg::SectorReset;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (accept) begin
        sub_step_q <= sub_step_d;
        sector_q   <= sector_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/scs_back.sv
// Result stage: sine lookup, amplitude scaling and the output register.
`default_nettype none

module scs_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        stage_valid_i,
  input  wire scs_pkg::stage_t             stage_i,
  output logic                             down_ready_o,
  input  wire logic [scs_pkg::DutyW-1:0]   floor_duty_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [scs_pkg::DutyW-1:0]        duty_phase1_o,
  output logic [scs_pkg::DutyW-1:0]        duty_phase2_o,
  output logic [scs_pkg::DutyW-1:0]        duty_phase3_o,
  output logic                             enable_pulse_o,
  output logic [scs_pkg::PeriodW-1:0]      timer_reload_o
);

  localparam int unsigned ProdW = scs_pkg::SineW + scs_pkg::AmpW;

  logic                                         valid_q;
  logic [scs_pkg::Phases-1:0][scs_pkg::DutyW-1:0] duty_d, duty_q;
  logic                                         enable_q;
  logic [scs_pkg::PeriodW-1:0]                  period_q;
  logic [ProdW-1:0]                             prod;
  logic                                         load;

  assign down_ready_o = !valid_q || out_ready_i;
  assign load         = stage_valid_i && down_ready_o;

  // Duty is the integer part of sine times amplitude, or the floor duty on an idle phase.
  always_comb begin
    prod = '0;
    for (int p = 0; p < scs_pkg::Phases; p++) begin
      prod = ProdW'(scs_pkg::sine_q16(stage_i.idx[p])) * ProdW'(stage_i.amp);
      duty_d[p] = stage_i.use_floor[p] ? floor_duty_i : prod[16 +: scs_pkg::DutyW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (down_ready_o) begin
      valid_q <= stage_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      duty_q   <= duty_d;
      enable_q <= stage_i.enable;
      period_q <= stage_i.period;
    end
  end

  assign out_valid_o    = valid_q;
  assign duty_phase1_o  = duty_q[0];
  assign duty_phase2_o  = duty_q[1];
  assign duty_phase3_o  = duty_q[2];
  assign enable_pulse_o = enable_q;
  assign timer_reload_o = period_q;

endmodule

`default_nettype wire

// File: rtl/sine_commutation_sequencer.sv
// Top level of the three-phase sine commutation sequencer.
//
// One input item per commutation tick carries the timer reload period on
// reload_period_i. Each item yields exactly one result item: three phase
// compare values, an enable pulse on the first tick of a sector and the
// period passed back out on timer_reload_o.
// Both item channels use valid/ready. The configuration channel writes
// the direction (index 0) and the idle-phase floor duty (index 1); it is
// always ready and should only be used while no item is in flight.
// Each item passes an input register holding the sequencer state and
// table indices, then a result register after the sine lookup and the
// 17 x 7 bit amplitude multiply.
// Throughput is one item per cycle. When the receiver stalls, the result
// register holds and the input register fills, after which in_ready_o
// drops until out_ready_i returns.
// Reset clears both stages, sets the sub-step to 0, the sector to 2,
// the direction to forward and the floor duty to 0.
`default_nettype none

module sine_commutation_sequencer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [scs_pkg::PeriodW-1:0]    reload_period_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [scs_pkg::DutyW-1:0]           duty_phase1_o,
  output logic [scs_pkg::DutyW-1:0]           duty_phase2_o,
  output logic [scs_pkg::DutyW-1:0]           duty_phase3_o,
  output logic                                enable_pulse_o,
  output logic [scs_pkg::PeriodW-1:0]         timer_reload_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [scs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [scs_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic                          forward_q;
  logic [scs_pkg::DutyW-1:0]     floor_duty_q;
  logic                          stage_valid;
  logic                          down_ready;
  scs_pkg::stage_t               stage;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forward_q    <= 1'b1;
      floor_duty_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        scs_pkg::CFG_FORWARD:    forward_q    <= cfg_data_i[0];
        scs_pkg::CFG_FLOOR_DUTY: floor_duty_q <= cfg_data_i[scs_pkg::DutyW-1:0];
        default: ;
      endcase
    end
  end

  scs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .reload_period_i (reload_period_i),
    .forward_i       (forward_q),
    .down_ready_i    (down_ready),
    .stage_valid_o   (stage_valid),
    .stage_o         (stage)
  );

  scs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stage_valid_i  (stage_valid),
    .stage_i        (stage),
    .down_ready_o   (down_ready),
    .floor_duty_i   (floor_duty_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .duty_phase1_o  (duty_phase1_o),
    .duty_phase2_o  (duty_phase2_o),
    .duty_phase3_o  (duty_phase3_o),
    .enable_pulse_o (enable_pulse_o),
    .timer_reload_o (timer_reload_o)
  );

endmodule

`default_nettype wire

// File: rtl/scs_checker.sv
// Port-level assertion checker for the sequencer, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module scs_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [scs_pkg::DutyW-1:0]      duty_phase1_o,
  input wire logic [scs_pkg::DutyW-1:0]      duty_phase2_o,
  input wire logic [scs_pkg::DutyW-1:0]      duty_phase3_o,
  input wire logic                           enable_pulse_o,
  input wire logic [scs_pkg::PeriodW-1:0]    timer_reload_o
);

  logic [scs_pkg::Phases*scs_pkg::DutyW+scs_pkg::PeriodW:0] result_bus;

  assign result_bus = {duty_phase1_o, duty_phase2_o, duty_phase3_o, enable_pulse_o,
                       timer_reload_o};

  // A stalled result holds still until it is taken.
  `SCS_ASSERT_IMPL(a_out_hold, out_valid_o && !out_ready_i, ##1 (out_valid_o && $stable(result_bus)))

  // With room at the output the input side never backs up.
  `SCS_ASSERT_IMPL(a_no_bubble, !out_valid_o || out_ready_i, in_ready_o)

  // A result appearing on an empty output went straight through the input and result registers.
  `SCS_ASSERT(a_latency, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))

endmodule

bind sine_commutation_sequencer scs_checker u_scs_checker (.*);

`default_nettype wire

// File: tb/sv/tb_sine_commutation_sequencer.sv
// Self-checking testbench for the three-phase sine commutation sequencer.
module tb_sine_commutation_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import scs_pkg::*;

  localparam int unsigned STEPS          = StepsPerSector;
  localparam int unsigned TABLE_LAST     = 39;
  localparam int unsigned PIPE_SETTLE    = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_OFF_LEN   = 150;

  localparam int unsigned SINE_Q16 [40] = '{
    3118, 6230, 9327, 12403, 15451, 18464, 21435, 24357,
    27225, 30030, 32768, 35431, 38015, 40512, 42917, 45225,
    47431, 49529, 51515, 53384, 55132, 56756, 58251, 59614,
    60842, 61932, 62881, 63689, 64352, 64869, 65239, 65462,
    65536, 65462, 65239, 64869, 64352, 63689, 62881, 61932
  };

  // Indexed by direction, sector and phase.
  localparam sel_e PHASE_SEL [2][6][3] = '{
    '{
      '{SEL_FLOOR, SEL_FALL2, SEL_FALL},
      '{SEL_FLOOR, SEL_RISE,  SEL_RISE2},
      '{SEL_FALL,  SEL_FLOOR, SEL_FALL2},
      '{SEL_RISE2, SEL_FLOOR, SEL_RISE},
      '{SEL_FALL2, SEL_FALL,  SEL_FLOOR},
      '{SEL_RISE,  SEL_RISE2, SEL_FLOOR}
    },
    '{
      '{SEL_FLOOR, SEL_FALL2, SEL_RISE},
      '{SEL_FLOOR, SEL_FALL,  SEL_RISE2},
      '{SEL_RISE,  SEL_FLOOR, SEL_FALL2},
      '{SEL_RISE2, SEL_FLOOR, SEL_FALL},
      '{SEL_FALL2, SEL_RISE,  SEL_FLOOR},
      '{SEL_FALL,  SEL_RISE2, SEL_FLOOR}
    }
  };

  localparam int unsigned AMP_EDGES [6] = '{160, 180, 270, 350, 570, 1300};

  typedef struct packed {
    logic [Phases-1:0][DutyW-1:0] duty;
    logic                         enable;
    logic [PeriodW-1:0]           reload;
  } tick_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [PeriodW-1:0]    reload_period_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [DutyW-1:0]      duty_phase1_o;
  logic [DutyW-1:0]      duty_phase2_o;
  logic [DutyW-1:0]      duty_phase3_o;
  logic                  enable_pulse_o;
  logic [PeriodW-1:0]    timer_reload_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  cfg_idx_e              cfg_index_i;
  logic [CfgDataW-1:0]   cfg_data_i;

  sine_commutation_sequencer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .reload_period_i (reload_period_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .duty_phase1_o   (duty_phase1_o),
    .duty_phase2_o   (duty_phase2_o),
    .duty_phase3_o   (duty_phase3_o),
    .enable_pulse_o  (enable_pulse_o),
    .timer_reload_o  (timer_reload_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Sequencer state as the testbench sees it.
  int unsigned          sub_step_q;
  logic [SectorW-1:0]   sector_q;
  logic                 dir_fwd;
  logic [DutyW-1:0]     floor_q;

  tick_result_t         pending_ticks[$];
  int unsigned          error_count;
  bit                   tx_steady;
  bit                   rx_steady;
  int unsigned          hold_off_cycles;

  function automatic int unsigned drive_amplitude(input logic [PeriodW-1:0] period);
    if (period > 1300)     return 10;
    else if (period > 570) return 20;
    else if (period > 350) return 30;
    else if (period > 270) return 40;
    else if (period > 180) return 50;
    else if (period > 160) return 60;
    return 70;
  endfunction

  function automatic logic [DutyW-1:0] phase_duty(input sel_e sel, input int unsigned i,
                                                  input int unsigned amp);
    int unsigned idx;
    case (sel)
      SEL_RISE:  idx = i;
      SEL_FALL:  idx = STEPS - 1 - i;
      SEL_RISE2: idx = i + STEPS;
      SEL_FALL2: idx = 2 * STEPS - 1 - i;
      default:   return floor_q;
    endcase
    if (idx > TABLE_LAST) idx = TABLE_LAST;
    return DutyW'((SINE_Q16[idx] * amp) >> 16);
  endfunction

  // Advances the sequencer by one tick and returns what the block should emit.
  function automatic tick_result_t commutate_tick(input logic [PeriodW-1:0] period);
    tick_result_t res;
    int unsigned  amp;
    sel_e         sel;
    amp = drive_amplitude(period);
    if (sub_step_q >= STEPS) begin
      sub_step_q = 0;
      if (dir_fwd) begin
        sector_q = (sector_q >= SectorLast) ? SectorFirst : sector_q + 1'b1;
      end else begin
        sector_q = (sector_q == SectorFirst) ? SectorLast : sector_q - 1'b1;
      end
    end
    for (int p = 0; p < Phases; p++) begin
      sel = (sector_q <= SectorLast) ? PHASE_SEL[dir_fwd][sector_q][p] : SEL_FLOOR;
      res.duty[p] = phase_duty(sel, sub_step_q, amp);
    end
    res.enable = (sub_step_q == 0);
    res.reload = period;
    sub_step_q++;
    return res;
  endfunction

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [PeriodW-1:0] pick_period();
    int unsigned edge_val;
    case ($urandom_range(0, 3))
      0: return PeriodW'($urandom_range(0, 65535));
      1: begin
        edge_val = AMP_EDGES[$urandom_range(0, 5)];
        return PeriodW'(edge_val + $urandom_range(0, 4) - 2);
      end
      2: return PeriodW'($urandom_range(0, 1400));
      default: return PeriodW'($urandom_range(1301, 65535));
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("tb: mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
    error_count++;
  endtask

  task automatic send_tick(input logic [PeriodW-1:0] period);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    reload_period_i <= period;
    do @(posedge clk_i); while (!in_ready_o);
    pending_ticks.push_back(commutate_tick(period));
    gap = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // The sender stops and waits until every result is back and the pipeline is empty.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk_i);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FORWARD:    dir_fwd = data[0];
      CFG_FLOOR_DUTY: floor_q = data;
      default:        ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_period_thresholds();
    logic [PeriodW-1:0] periods [21] = '{
      16'd0, 16'd1, 16'd160, 16'd161, 16'd180, 16'd181, 16'd270, 16'd271,
      16'd350, 16'd351, 16'd570, 16'd571, 16'd1300, 16'd1301, 16'hFFFF,
      16'h5555, 16'hAAAA, 16'd100, 16'd200, 16'd300, 16'd400
    };
    // Twenty-one ticks with default settings cross into the next sector.
    foreach (periods[k]) send_tick(periods[k]);
    drain_pipeline();
  endtask

  task automatic test_floor_extremes();
    write_reg(CFG_FLOOR_DUTY, 8'hFF);
    write_reg(CFG_FORWARD, 8'h00);
    send_tick(16'd0);
    send_tick(16'hFFFF);
    send_tick(16'd161);
    send_tick(16'd1300);
    drain_pipeline();
  endtask

  task automatic test_config_sweep();
    logic [CfgDataW-1:0] fwd_data;
    logic [CfgDataW-1:0] floor_data;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin fwd_data = 8'h01; floor_data = 8'h00; end
        1: begin fwd_data = 8'h00; floor_data = 8'hFF; end
        2: begin fwd_data = 8'hFF; floor_data = 8'hFF; end
        3: begin fwd_data = 8'hFE; floor_data = 8'h00; end
        default: begin
          fwd_data   = CfgDataW'($urandom_range(0, 255));
          floor_data = CfgDataW'($urandom_range(0, 255));
        end
      endcase
      write_reg(CFG_FORWARD, fwd_data);
      write_reg(CFG_FLOOR_DUTY, floor_data);
      repeat (90) send_tick(pick_period());
      drain_pipeline();
    end
  endtask

  task automatic test_backpressure();
    // The receiver holds off while the sender keeps offering, so the input stalls.
    @(negedge clk_i);
    hold_off_cycles = HOLD_OFF_LEN;
    tx_steady = 1'b1;
    repeat (24) send_tick(pick_period());
    drain_pipeline();
    rx_steady = 1'b1;
    repeat (60) send_tick(pick_period());
    drain_pipeline();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_random_stream();
    write_reg(CFG_FORWARD, 8'h01);
    write_reg(CFG_FLOOR_DUTY, CfgDataW'($urandom_range(0, 255)));
    repeat (550) send_tick(pick_period());
    drain_pipeline();
    write_reg(CFG_FORWARD, 8'h00);
    write_reg(CFG_FLOOR_DUTY, CfgDataW'($urandom_range(0, 255)));
    repeat (550) send_tick(pick_period());
    drain_pipeline();
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    tick_result_t want;
    logic [Phases-1:0][DutyW-1:0] got_duty;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_duty = {duty_phase3_o, duty_phase2_o, duty_phase1_o};
      if (pending_ticks.size() == 0) begin
        report_mismatch("unexpected result", timer_reload_o, 0);
      end else begin
        want = pending_ticks.pop_front();
        for (int p = 0; p < Phases; p++) begin
          if (got_duty[p] !== want.duty[p])
            report_mismatch($sformatf("duty_phase%0d", p + 1), got_duty[p], want.duty[p]);
        end
        if (enable_pulse_o !== want.enable)
          report_mismatch("enable_pulse", enable_pulse_o, want.enable);
        if (timer_reload_o !== want.reload)
          report_mismatch("timer_reload", timer_reload_o, want.reload);
      end
    end
  end

  // Receiver: random stalls, the occasional long hold-off, and steady stretches.
  initial begin : receiver
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles != 0) begin
        hold_off_cycles--;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!rx_steady && $urandom_range(0, 4) == 0) begin
        stall_left = idle_len() - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : main
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    reload_period_i = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_FORWARD;
    cfg_data_i      = '0;
    error_count     = 0;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    hold_off_cycles = 0;
    sub_step_q      = 0;
    sector_q        = SectorReset;
    dir_fwd         = 1'b1;
    floor_q         = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_period_thresholds();
    test_floor_extremes();
    test_config_sweep();
    test_backpressure();
    test_random_stream();

    repeat (PIPE_SETTLE) @(posedge clk_i);
    if (error_count == 0 && pending_ticks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
